[rtl/core/tiew_pkg.sv]
// Shared types and constants of the Tomasulo issue, execute and write-back block.
`timescale 1ns / 1ps
package tiew_pkg;

  localparam int DATA_W   = 32;
  localparam int TAG_W    = 4;
  localparam int LAT_W    = 6;
  localparam int NUM_OPS  = 6;
  localparam int OP_W     = 3;
  localparam int RFLD_W   = 5;
  localparam int OFF_W    = 16;
  localparam int MODE_W   = 2;
  localparam int KIND_W   = 2;
  localparam int CADDR_W  = 5;

  localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB   = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL   = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV   = 3'd3;
  localparam logic [OP_W-1:0] OP_LOAD  = 3'd4;
  localparam logic [OP_W-1:0] OP_STORE = 3'd5;

  localparam logic [MODE_W-1:0] MODE_CYCLE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PRELOAD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_END   = 2'd0,
    KIND_BCAST = 2'd1,
    KIND_STORE = 2'd2,
    KIND_READ  = 2'd3
  } tiew_kind_e;

  typedef enum logic [1:0] {
    RD_SRC1   = 2'd0,
    RD_SRC2   = 2'd1,
    RD_TARGET = 2'd2
  } tiew_rd_sel_e;

  typedef enum logic [1:0] {
    RES_ALU = 2'd0,
    RES_MUL = 2'd1,
    RES_DIV = 2'd2
  } tiew_res_src_e;

  typedef logic [NUM_OPS-1:0][LAT_W-1:0] tiew_lat_t;

  localparam tiew_lat_t LAT_RST = {6'd2, 6'd2, 6'd40, 6'd10, 6'd2, 6'd2};

  typedef struct packed {
    logic          in_ready;
    logic          preload;
    logic          rd_en;
    tiew_rd_sel_e  rd_sel;
    logic          cap1;
    logic          commit;
    logic          cycle_inc;
    logic          exec;
    logic          scan_start;
    logic          scan_next;
    logic          mul_ld;
    logic          div_start;
    logic          res_ld;
    tiew_res_src_e res_src;
    logic          bcast;
    logic          free_st;
    logic          emit;
    tiew_kind_e    emit_kind;
  } tiew_cmd_t;

  typedef struct packed {
    logic              in_fire;
    logic [MODE_W-1:0] mode;
    logic              can_issue;
    logic              scan_end;
    logic              cur_fin;
    logic [OP_W-1:0]   cur_op;
    logic              div_done;
    logic              out_free;
  } tiew_status_t;

endpackage

[rtl/core/tiew_if.sv]
// Valid/ready channel interfaces for instruction beats and result beats.
`timescale 1ns / 1ps
interface tiew_in_if import tiew_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic              inst_valid;
  logic [OP_W-1:0]   opcode;
  logic [RFLD_W-1:0] target_reg;
  logic [RFLD_W-1:0] left_reg;
  logic [RFLD_W-1:0] right_reg;
  logic [OFF_W-1:0]  mem_offset;
  logic [DATA_W-1:0] reg_data;

  modport source (output valid, mode, inst_valid, opcode, target_reg, left_reg, right_reg,
                  mem_offset, reg_data, input ready);
  modport sink (input valid, mode, inst_valid, opcode, target_reg, left_reg, right_reg,
                mem_offset, reg_data, output ready);
endinterface

interface tiew_out_if import tiew_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [TAG_W-1:0]  tag;
  logic [DATA_W-1:0] value;
  logic              issued;
  logic              last;

  modport source (output valid, kind, tag, value, issued, last, input ready);
  modport sink (input valid, kind, tag, value, issued, last, output ready);
endinterface

[rtl/core/tomasulo_issue_execute_writeback.sv]
// Top level: latency registers on the APB port, controller and datapath.
// A preload beat writes its register at decode; a register read is registered at decode and
// emitted from the read state. A clock beat reads sources and commits if an instruction issues,
// executes, scans the stations in order and ends with the cycle end beat; add, sub and load
// results broadcast directly, multiplies via a register, divides via the serial divider.
// Reset is asynchronous and clears control state, tags, stations and the register valid bits.
`timescale 1ns / 1ps
module tomasulo_issue_execute_writeback import tiew_pkg::*; #(
  parameter int NUM_REGS     = 32,
  parameter int ADD_STATIONS = 3,
  parameter int MUL_STATIONS = 2,
  parameter int MEM_STATIONS = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  tiew_in_if.sink            in_i,
  tiew_out_if.source         out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);
  tiew_lat_t    lat_q;
  tiew_cmd_t    cmd;
  tiew_status_t status;
  logic [2:0]   cfg_ix;

  assign cfg_ix = paddr[CADDR_W-1:2];
  assign pready = 1'b1;
  assign prdata = (cfg_ix < 3'(NUM_OPS)) ? DATA_W'(lat_q[cfg_ix]) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_q <= LAT_RST;
    end else if (psel && penable && pwrite && cfg_ix < 3'(NUM_OPS)) begin
      lat_q[cfg_ix] <= pwdata[LAT_W-1:0];
    end
  end

  tiew_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  tiew_dp #(
    .NUM_REGS     (NUM_REGS),
    .ADD_STATIONS (ADD_STATIONS),
    .MUL_STATIONS (MUL_STATIONS),
    .MEM_STATIONS (MEM_STATIONS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .out_o    (out_o),
    .lat_i    (lat_q),
    .cmd_i    (cmd),
    .status_o (status)
  );

  a_one_beat_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("Input accepted while an item is still in progress.");

  a_read_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.kind == KIND_READ |-> out_o.last && !out_o.issued)
    else $error("Register read beat is not a final, non-issuing beat.");

  a_end_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.kind == KIND_END |-> out_o.last && out_o.tag == '0)
    else $error("Cycle end beat is malformed.");

  a_no_issue_and_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> !cmd.emit && !cmd.bcast)
    else $error("Issue overlaps with write-back.");
endmodule

[rtl/core/tiew_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module tiew_div import tiew_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] dividend_i,
  input  logic [DATA_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DATA_W-1:0] quot_o
);
  localparam int CNT_W = $clog2(DATA_W);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DATA_W-1:0] rem_q;
  logic [DATA_W-1:0] quo_q;
  logic [DATA_W-1:0] dvs_q;
  logic [DATA_W:0]   trial;
  logic              fits;

  assign trial = {rem_q, quo_q[DATA_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DATA_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? DATA_W'(trial - {1'b0, dvs_q}) : DATA_W'(trial);
      quo_q <= {quo_q[DATA_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
endmodule

[rtl/core/tiew_dp.sv]
// Datapath: register file, tags, reservation stations, functional units and result register.
`timescale 1ns / 1ps
module tiew_dp import tiew_pkg::*; #(
  parameter int NUM_REGS     = 32,
  parameter int ADD_STATIONS = 3,
  parameter int MUL_STATIONS = 2,
  parameter int MEM_STATIONS = 3
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tiew_in_if.sink      in_i,
  tiew_out_if.source   out_o,
  input  tiew_lat_t    lat_i,
  input  tiew_cmd_t    cmd_i,
  output tiew_status_t status_o
);
  localparam int NST    = ADD_STATIONS + MUL_STATIONS + MEM_STATIONS;
  localparam int MEM_LO = ADD_STATIONS + MUL_STATIONS;
  localparam int SW     = $clog2(NST);
  localparam int IW     = $clog2(NST + 1);
  localparam int RW     = $clog2(NUM_REGS);

  function automatic logic [RW-1:0] reg_ix(input logic [RFLD_W-1:0] r);
    logic [RFLD_W:0] v;
    v = {1'b0, r};
    for (int k = RFLD_W - 1; k >= 0; k--) begin
      if (int'(v) >= (NUM_REGS << k)) begin
        v = v - (RFLD_W + 1)'(NUM_REGS << k);
      end
    end
    return RW'(v);
  endfunction

  // Latched input beat.
  logic [MODE_W-1:0] mode_q;
  logic              inst_valid_q;
  logic [OP_W-1:0]   op_q;
  logic [RFLD_W-1:0] tgt_q, left_q, right_q;
  logic [OFF_W-1:0]  off_q;
  logic [DATA_W-1:0] rdat_q;
  logic              in_fire;

  assign in_i.ready = cmd_i.in_ready;
  assign in_fire    = in_i.valid && cmd_i.in_ready;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q       <= in_i.mode;
      inst_valid_q <= in_i.inst_valid;
      op_q         <= in_i.opcode;
      tgt_q        <= in_i.target_reg;
      left_q       <= in_i.left_reg;
      right_q      <= in_i.right_reg;
      off_q        <= in_i.mem_offset;
      rdat_q       <= in_i.reg_data;
    end
  end

  logic [RW-1:0] ix_t, ix_l, ix_r;
  logic          arith;
  assign ix_t  = reg_ix(tgt_q);
  assign ix_l  = reg_ix(left_q);
  assign ix_r  = reg_ix(right_q);
  assign arith = op_q < OP_LOAD;

  // Register file: values in memory, valid bits and pending tags in flops.
  logic [DATA_W-1:0]   rf_mem [NUM_REGS];
  logic [NUM_REGS-1:0] rf_vld_q;
  logic [TAG_W-1:0]    pend_q [NUM_REGS];
  logic [RW-1:0]       rd_addr;
  logic [DATA_W-1:0]   rd_data_q;
  logic                rd_vld_q;
  logic [TAG_W-1:0]    rd_tag_q;
  logic [DATA_W-1:0]   rd_val;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_SRC1:   rd_addr = arith ? ix_l : ix_r;
      RD_SRC2:   rd_addr = arith ? ix_r : ix_t;
      RD_TARGET: rd_addr = ix_t;
      default:   rd_addr = ix_t;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q <= rf_mem[rd_addr];
      rd_vld_q  <= rf_vld_q[rd_addr];
      rd_tag_q  <= pend_q[rd_addr];
    end
  end
  assign rd_val = rd_vld_q ? rd_data_q : '0;

  // Station scan.
  logic [IW-1:0]     idx_q;
  logic [SW-1:0]     cs;
  logic [TAG_W-1:0]  cur_id;
  logic              scan_end;

  assign cs       = idx_q[SW-1:0];
  assign cur_id   = TAG_W'(cs) + TAG_W'(1);
  assign scan_end = idx_q == IW'(NST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.scan_start) begin
      idx_q <= '0;
    end else if (cmd_i.scan_next) begin
      idx_q <= idx_q + IW'(1);
    end
  end

  // Reservation stations.
  logic              st_busy_q [NST];
  logic [OP_W-1:0]   st_op_q   [NST];
  logic [DATA_W-1:0] st_vj_q   [NST];
  logic [DATA_W-1:0] st_vk_q   [NST];
  logic [TAG_W-1:0]  st_qj_q   [NST];
  logic [TAG_W-1:0]  st_qk_q   [NST];
  logic [DATA_W-1:0] st_addr_q [NST];
  logic              st_done_q [NST];
  logic [LAT_W-1:0]  st_rem_q  [NST];

  logic [DATA_W-1:0] vj1_q;
  logic [TAG_W-1:0]  qj1_q;
  logic              free_found;
  logic [SW-1:0]     free_ix;
  logic [TAG_W-1:0]  new_id;
  logic [LAT_W-1:0]  lat_sel, lat_eff;
  logic [DATA_W-1:0] res_q;

  always_comb begin
    int lo, hi;
    lo = (op_q < OP_MUL) ? 0 : (op_q < OP_LOAD) ? ADD_STATIONS : MEM_LO;
    hi = (op_q < OP_MUL) ? ADD_STATIONS : (op_q < OP_LOAD) ? MEM_LO : NST;
    free_found = 1'b0;
    free_ix    = '0;
    for (int i = NST - 1; i >= 0; i--) begin
      if (i >= lo && i < hi && !st_busy_q[i]) begin
        free_found = 1'b1;
        free_ix    = SW'(i);
      end
    end
  end

  assign new_id  = TAG_W'(free_ix) + TAG_W'(1);
  assign lat_sel = lat_i[op_q];
  assign lat_eff = (lat_sel == '0) ? LAT_W'(1) : lat_sel;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap1) begin
      vj1_q <= rd_val;
      qj1_q <= rd_tag_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NST; i++) begin
        st_busy_q[i] <= 1'b0;
        st_qj_q[i]   <= '0;
        st_qk_q[i]   <= '0;
        st_done_q[i] <= 1'b0;
        st_rem_q[i]  <= '0;
      end
    end else begin
      if (cmd_i.commit) begin
        st_busy_q[free_ix] <= 1'b1;
        st_rem_q[free_ix]  <= lat_eff;
        st_done_q[free_ix] <= 1'b0;
        st_qj_q[free_ix]   <= qj1_q;
        st_qk_q[free_ix]   <= (op_q == OP_LOAD) ? '0 : rd_tag_q;
      end
      if (cmd_i.exec) begin
        for (int i = 0; i < NST; i++) begin
          if (st_busy_q[i] && st_qj_q[i] == '0) begin
            if (i >= MEM_LO) begin
              st_done_q[i] <= 1'b1;
              if (st_rem_q[i] != '0) st_rem_q[i] <= st_rem_q[i] - LAT_W'(1);
            end else if (st_qk_q[i] == '0 && st_rem_q[i] != '0) begin
              st_rem_q[i] <= st_rem_q[i] - LAT_W'(1);
            end
          end
        end
      end
      if (cmd_i.bcast) begin
        for (int j = 0; j < NST; j++) begin
          if (st_qj_q[j] == cur_id) st_qj_q[j] <= '0;
          if (st_qk_q[j] == cur_id) st_qk_q[j] <= '0;
        end
      end
      if (cmd_i.bcast || cmd_i.free_st) begin
        st_busy_q[cs] <= 1'b0;
        st_qj_q[cs]   <= '0;
        st_qk_q[cs]   <= '0;
        st_done_q[cs] <= 1'b0;
        st_rem_q[cs]  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      st_op_q[free_ix]   <= op_q;
      st_vj_q[free_ix]   <= vj1_q;
      st_vk_q[free_ix]   <= rd_val;
      st_addr_q[free_ix] <= DATA_W'(off_q);
    end
    if (cmd_i.exec) begin
      for (int i = MEM_LO; i < NST; i++) begin
        if (st_busy_q[i] && st_qj_q[i] == '0 && !st_done_q[i]) begin
          st_addr_q[i] <= st_vj_q[i] + st_addr_q[i];
        end
      end
    end
    if (cmd_i.bcast) begin
      for (int j = 0; j < NST; j++) begin
        if (st_qj_q[j] == cur_id) st_vj_q[j] <= res_q;
        if (st_qk_q[j] == cur_id) st_vk_q[j] <= res_q;
      end
    end
  end

  // Register file writes: preload, and the broadcast to the register renamed to this station.
  logic          hit;
  logic [RW-1:0] hit_ix;
  logic          rf_we;
  logic [RW-1:0] rf_waddr;

  always_comb begin
    hit    = 1'b0;
    hit_ix = '0;
    for (int r = 0; r < NUM_REGS; r++) begin
      if (pend_q[r] == cur_id) begin
        hit    = 1'b1;
        hit_ix = RW'(r);
      end
    end
  end

  assign rf_we    = cmd_i.preload || (cmd_i.bcast && hit);
  assign rf_waddr = cmd_i.preload ? ix_t : hit_ix;

  always_ff @(posedge clk_i) begin
    if (rf_we) rf_mem[rf_waddr] <= cmd_i.preload ? rdat_q : res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
      for (int r = 0; r < NUM_REGS; r++) pend_q[r] <= '0;
    end else begin
      if (rf_we) rf_vld_q[rf_waddr] <= 1'b1;
      if (cmd_i.bcast && hit) pend_q[hit_ix] <= '0;
      if (cmd_i.commit && op_q != OP_STORE) pend_q[ix_t] <= new_id;
    end
  end

  // Functional units.
  logic [DATA_W-1:0] cur_vj, cur_vk, alu_res, prod_q, div_q, prod_lo;
  logic              div_done;

  assign cur_vj  = st_vj_q[cs];
  assign cur_vk  = st_vk_q[cs];
  assign prod_lo = cur_vj * cur_vk;

  always_comb begin
    case (st_op_q[cs])
      OP_ADD:  alu_res = cur_vj + cur_vk;
      OP_SUB:  alu_res = cur_vj - cur_vk;
      OP_LOAD: alu_res = st_addr_q[cs];
      default: alu_res = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_ld) prod_q <= prod_lo;
    if (cmd_i.res_ld) begin
      case (cmd_i.res_src)
        RES_ALU: res_q <= alu_res;
        RES_MUL: res_q <= prod_q;
        RES_DIV: res_q <= div_q;
        default: res_q <= alu_res;
      endcase
    end
  end

  tiew_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (cur_vj),
    .divisor_i  (cur_vk),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  // Cycle counter, issue flag and output register.
  logic [DATA_W-1:0] cyc_q;
  logic              issued_q;
  logic              out_valid_q;
  logic [KIND_W-1:0] out_kind_q;
  logic [TAG_W-1:0]  out_tag_q;
  logic [DATA_W-1:0] out_value_q;
  logic              out_issued_q;
  logic              out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cyc_q       <= '0;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cycle_inc) begin
        cyc_q    <= cyc_q + DATA_W'(1);
        issued_q <= 1'b0;
      end
      if (cmd_i.commit) issued_q <= 1'b1;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_kind_q   <= cmd_i.emit_kind;
      out_issued_q <= (cmd_i.emit_kind == KIND_READ) ? 1'b0 : issued_q;
      out_last_q   <= (cmd_i.emit_kind == KIND_END) || (cmd_i.emit_kind == KIND_READ);
      case (cmd_i.emit_kind)
        KIND_END: begin
          out_tag_q   <= '0;
          out_value_q <= cyc_q;
        end
        KIND_BCAST: begin
          out_tag_q   <= cur_id;
          out_value_q <= res_q;
        end
        KIND_STORE: begin
          out_tag_q   <= cur_id;
          out_value_q <= '0;
        end
        KIND_READ: begin
          out_tag_q   <= rd_tag_q;
          out_value_q <= rd_val;
        end
        default: begin
          out_tag_q   <= '0;
          out_value_q <= '0;
        end
      endcase
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.kind   = out_kind_q;
  assign out_o.tag    = out_tag_q;
  assign out_o.value  = out_value_q;
  assign out_o.issued = out_issued_q;
  assign out_o.last   = out_last_q;

  assign status_o.in_fire   = in_fire;
  assign status_o.mode      = mode_q;
  assign status_o.can_issue = inst_valid_q && (op_q <= OP_STORE) && free_found;
  assign status_o.scan_end  = scan_end;
  assign status_o.cur_fin   = !scan_end && st_busy_q[cs] && (st_rem_q[cs] == '0);
  assign status_o.cur_op    = st_op_q[cs];
  assign status_o.div_done  = div_done;
  assign status_o.out_free  = !out_valid_q || out_o.ready;
endmodule

[rtl/core/tiew_ctrl.sv]
// Controller state machine sequencing preload, register read, issue, execute and the serial write-back scan.
`timescale 1ns / 1ps
module tiew_ctrl import tiew_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  tiew_status_t status_i,
  output tiew_cmd_t    cmd_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SRC2, S_COMMIT, S_EXEC, S_SCAN, S_MUL, S_DIV, S_BC, S_READ
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (status_i.in_fire) state_d = S_DECODE;
      end
      S_DECODE: begin
        case (status_i.mode)
          MODE_CYCLE: begin
            cmd_o.cycle_inc = 1'b1;
            if (status_i.can_issue) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RD_SRC1;
              state_d      = S_SRC2;
            end else begin
              state_d = S_EXEC;
            end
          end
          MODE_PRELOAD: begin
            cmd_o.preload = 1'b1;
            state_d       = S_IDLE;
          end
          MODE_READ: begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RD_TARGET;
            state_d      = S_READ;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_SRC2: begin
        cmd_o.cap1   = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_SRC2;
        state_d      = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec       = 1'b1;
        cmd_o.scan_start = 1'b1;
        state_d          = S_SCAN;
      end
      S_SCAN: begin
        if (status_i.scan_end) begin
          if (status_i.out_free) begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_kind = KIND_END;
            state_d         = S_IDLE;
          end
        end else if (!status_i.cur_fin) begin
          cmd_o.scan_next = 1'b1;
        end else if (status_i.cur_op == OP_STORE) begin
          if (status_i.out_free) begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_kind = KIND_STORE;
            cmd_o.free_st   = 1'b1;
            cmd_o.scan_next = 1'b1;
          end
        end else if (status_i.cur_op == OP_MUL) begin
          cmd_o.mul_ld = 1'b1;
          state_d      = S_MUL;
        end else if (status_i.cur_op == OP_DIV) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          cmd_o.res_ld  = 1'b1;
          cmd_o.res_src = RES_ALU;
          state_d       = S_BC;
        end
      end
      S_MUL: begin
        cmd_o.res_ld  = 1'b1;
        cmd_o.res_src = RES_MUL;
        state_d       = S_BC;
      end
      S_DIV: begin
        if (status_i.div_done) begin
          cmd_o.res_ld  = 1'b1;
          cmd_o.res_src = RES_DIV;
          state_d       = S_BC;
        end
      end
      S_BC: begin
        if (status_i.out_free) begin
          cmd_o.bcast     = 1'b1;
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = KIND_BCAST;
          cmd_o.scan_next = 1'b1;
          state_d         = S_SCAN;
        end
      end
      S_READ: begin
        if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = KIND_READ;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

[dv/tomasulo_issue_execute_writeback_tb.sv]
// Self-checking testbench of the Tomasulo block: directed and random beats against a cycle-item predictor.
`timescale 1ns / 1ps
module tomasulo_issue_execute_writeback_tb;
  import tiew_pkg::*;

  localparam int NREG   = 32;
  localparam int N_ADD  = 3;
  localparam int N_MUL  = 2;
  localparam int NST    = 8;
  localparam int LIMIT  = 1000000;
  localparam int SETTLE = 12;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              inst_valid;
    logic [OP_W-1:0]   opcode;
    logic [RFLD_W-1:0] target_reg;
    logic [RFLD_W-1:0] left_reg;
    logic [RFLD_W-1:0] right_reg;
    logic [OFF_W-1:0]  mem_offset;
    logic [DATA_W-1:0] reg_data;
  } instr_t;

  typedef struct packed {
    tiew_kind_e        kind;
    logic [TAG_W-1:0]  tag;
    logic [DATA_W-1:0] value;
    logic              issued;
    logic              last;
  } result_t;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite;
  logic [CADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  logic pready;

  tiew_in_if  in_bus ();
  tiew_out_if out_bus ();

  tomasulo_issue_execute_writeback DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  instr_t  instr_q[$];
  result_t expected_q[$];
  int      errors = 0;
  int      cycles = 0;
  bit      no_idle = 0;
  bit      beat_taken = 0;
  int      send_gap = 0;
  int      recv_stall = 0;

  logic [DATA_W-1:0] rf_value[NREG];
  logic [TAG_W-1:0]  rf_tag[NREG];
  bit                st_busy[NST];
  logic [OP_W-1:0]   st_op[NST];
  logic [DATA_W-1:0] st_vj[NST], st_vk[NST], st_addr[NST];
  logic [TAG_W-1:0]  st_qj[NST], st_qk[NST];
  bit                st_addr_done[NST];
  logic [LAT_W-1:0]  st_left[NST];
  logic [DATA_W-1:0] cycle_cnt;
  logic [LAT_W-1:0]  latency[NUM_OPS];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic source_read(input int r, inout logic [DATA_W-1:0] v,
                             inout logic [TAG_W-1:0] q);
    if (rf_tag[r] != 0) begin
      q = rf_tag[r];
    end else begin
      v = rf_value[r];
      q = '0;
    end
  endtask

  function automatic logic [DATA_W-1:0] station_result(int i);
    logic [DATA_W-1:0] a, b;
    a = st_vj[i];
    b = st_vk[i];
    case (st_op[i])
      OP_ADD:  return a + b;
      OP_SUB:  return a - b;
      OP_MUL:  return a * b;
      OP_DIV:  return (b == 0) ? '1 : a / b;
      OP_LOAD: return st_addr[i];
      default: return '0;
    endcase
  endfunction

  task automatic predict_instr(input instr_t it);
    int lo, hi, s, t, a, b;
    logic issued;
    logic [LAT_W-1:0] lat;
    logic [DATA_W-1:0] v;
    logic [TAG_W-1:0] id;
    issued = 1'b0;
    t = it.target_reg % NREG;
    a = it.left_reg % NREG;
    b = it.right_reg % NREG;
    if (it.mode == MODE_PRELOAD) begin
      rf_value[t] = it.reg_data;
    end else if (it.mode == MODE_READ) begin
      expected_q.push_back('{KIND_READ, rf_tag[t], rf_value[t], 1'b0, 1'b1});
    end else if (it.mode == MODE_CYCLE) begin
      cycle_cnt++;
      if (it.inst_valid && it.opcode <= OP_STORE) begin
        if (it.opcode < OP_MUL) begin
          lo = 0; hi = N_ADD;
        end else if (it.opcode < OP_LOAD) begin
          lo = N_ADD; hi = N_ADD + N_MUL;
        end else begin
          lo = N_ADD + N_MUL; hi = NST;
        end
        s = NST;
        for (int i = lo; i < hi; i++)
          if (!st_busy[i] && s == NST) s = i;
        if (s != NST) begin
          issued = 1'b1;
          lat = latency[it.opcode];
          if (lat == 0) lat = 1;
          st_busy[s] = 1;
          st_op[s] = it.opcode;
          st_left[s] = lat;
          st_qj[s] = '0;
          st_qk[s] = '0;
          st_addr_done[s] = 0;
          if (it.opcode < OP_LOAD) begin
            source_read(a, st_vj[s], st_qj[s]);
            source_read(b, st_vk[s], st_qk[s]);
            rf_tag[t] = TAG_W'(s + 1);
          end else begin
            source_read(b, st_vj[s], st_qj[s]);
            st_addr[s] = DATA_W'(it.mem_offset);
            if (it.opcode == OP_LOAD) rf_tag[t] = TAG_W'(s + 1);
            else source_read(t, st_vk[s], st_qk[s]);
          end
        end
      end
      for (int i = 0; i < NST; i++) begin
        if (st_busy[i] && st_qj[i] == 0) begin
          if (i >= N_ADD + N_MUL) begin
            if (!st_addr_done[i]) begin
              st_addr[i] = st_vj[i] + st_addr[i];
              st_addr_done[i] = 1;
            end
            if (st_left[i] > 0) st_left[i]--;
          end else if (st_qk[i] == 0) begin
            if (st_left[i] > 0) st_left[i]--;
          end
        end
      end
      for (int i = 0; i < NST; i++) begin
        if (st_busy[i] && st_left[i] == 0) begin
          id = TAG_W'(i + 1);
          if (st_op[i] == OP_STORE) begin
            expected_q.push_back('{KIND_STORE, id, '0, issued, 1'b0});
          end else begin
            v = station_result(i);
            for (int r = 0; r < NREG; r++)
              if (rf_tag[r] == id) begin
                rf_value[r] = v;
                rf_tag[r] = '0;
              end
            for (int j = 0; j < NST; j++) begin
              if (st_qj[j] == id) begin st_vj[j] = v; st_qj[j] = '0; end
              if (st_qk[j] == id) begin st_vk[j] = v; st_qk[j] = '0; end
            end
            expected_q.push_back('{KIND_BCAST, id, v, issued, 1'b0});
          end
          st_busy[i] = 0;
          st_qj[i] = '0;
          st_qk[i] = '0;
          st_addr_done[i] = 0;
          st_left[i] = '0;
        end
      end
      expected_q.push_back('{KIND_END, '0, cycle_cnt, issued, 1'b1});
    end
  endtask

  // Input beats are predicted as they are accepted; result beats are checked in order.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    if (rst_ni && in_bus.valid && in_bus.ready) begin
      predict_instr(instr_t'({in_bus.mode, in_bus.inst_valid, in_bus.opcode, in_bus.target_reg,
                              in_bus.left_reg, in_bus.right_reg, in_bus.mem_offset,
                              in_bus.reg_data}));
      beat_taken = 1;
    end
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      result_t got;
      got = '{tiew_kind_e'(out_bus.kind), out_bus.tag, out_bus.value, out_bus.issued,
              out_bus.last};
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result beat: %p", got);
      end else begin
        result_t exp_r;
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          errors++;
          if (errors <= 10) $display("Mismatch: expected %p, got %p", exp_r, got);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_bus.valid || beat_taken) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_bus.valid <= 1'b0;
        end else if (!no_idle && $urandom_range(9) == 0) begin
          send_gap <= $urandom_range(18);
          in_bus.valid <= 1'b0;
        end else if (instr_q.size() > 0) begin
          instr_t it;
          it = instr_q.pop_front();
          in_bus.valid      <= 1'b1;
          in_bus.mode       <= it.mode;
          in_bus.inst_valid <= it.inst_valid;
          in_bus.opcode     <= it.opcode;
          in_bus.target_reg <= it.target_reg;
          in_bus.left_reg   <= it.left_reg;
          in_bus.right_reg  <= it.right_reg;
          in_bus.mem_offset <= it.mem_offset;
          in_bus.reg_data   <= it.reg_data;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
      beat_taken = 0;
      if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        out_bus.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(11) == 0) begin
        recv_stall <= $urandom_range(18);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  task automatic write_latency(input int idx, input logic [LAT_W-1:0] val);
    @(negedge clk_i);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = CADDR_W'(4 * idx); pwdata = DATA_W'(val);
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    latency[idx] = val;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while ((instr_q.size() > 0 || in_bus.valid || expected_q.size() > 0) && guard < LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic instr_t mk(logic [MODE_W-1:0] m, logic iv, logic [OP_W-1:0] op,
                                int t, int a, int b, logic [OFF_W-1:0] off,
                                logic [DATA_W-1:0] d);
    return '{m, iv, op, RFLD_W'(t), RFLD_W'(a), RFLD_W'(b), off, d};
  endfunction

  function automatic instr_t random_instr();
    instr_t it;
    int p;
    it = instr_t'({$urandom, $urandom, $urandom});
    p = $urandom_range(99);
    if (p < 8) begin
      it.mode = MODE_PRELOAD;
      if ($urandom_range(3) == 0) it.reg_data = '0;
    end else if (p < 18) begin
      it.mode = MODE_READ;
    end else if (p < 20) begin
      it.mode = 2'd3;
    end else begin
      it.mode = MODE_CYCLE;
      it.inst_valid = ($urandom_range(9) < 7);
      it.opcode = ($urandom_range(19) == 0) ? OP_W'($urandom_range(7))
                                            : OP_W'($urandom_range(5));
    end
    return it;
  endfunction

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_bus.valid = 1'b0; in_bus.mode = MODE_CYCLE; in_bus.inst_valid = 1'b0;
    in_bus.opcode = OP_ADD; in_bus.target_reg = '0; in_bus.left_reg = '0;
    in_bus.right_reg = '0; in_bus.mem_offset = '0; in_bus.reg_data = '0;
    out_bus.ready = 1'b0;
    for (int r = 0; r < NREG; r++) begin rf_value[r] = '0; rf_tag[r] = '0; end
    for (int i = 0; i < NST; i++) begin
      st_busy[i] = 0; st_op[i] = '0; st_vj[i] = '0; st_vk[i] = '0; st_addr[i] = '0;
      st_qj[i] = '0; st_qk[i] = '0; st_addr_done[i] = 0; st_left[i] = '0;
    end
    cycle_cnt = '0;
    for (int k = 0; k < NUM_OPS; k++) latency[k] = LAT_RST[k];
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    instr_q.push_back(mk(MODE_PRELOAD, 0, OP_ADD, 1, 0, 0, 0, 32'hFFFF_FFFF));
    instr_q.push_back(mk(MODE_PRELOAD, 0, OP_ADD, 2, 0, 0, 0, 32'h8000_0000));
    instr_q.push_back(mk(MODE_PRELOAD, 0, OP_ADD, 4, 0, 0, 0, 32'd7));
    instr_q.push_back(mk(MODE_PRELOAD, 0, OP_ADD, 31, 0, 0, 0, 32'd1));
    instr_q.push_back(mk(MODE_READ, 0, OP_ADD, 1, 0, 0, 0, 0));
    instr_q.push_back(mk(MODE_CYCLE, 1, OP_ADD, 5, 1, 2, 0, 0));
    instr_q.push_back(mk(MODE_CYCLE, 1, OP_SUB, 6, 3, 1, 0, 0));
    instr_q.push_back(mk(MODE_CYCLE, 1, OP_MUL, 7, 1, 1, 0, 0));
    instr_q.push_back(mk(MODE_CYCLE, 1, OP_DIV, 8, 1, 3, 0, 0));
    instr_q.push_back(mk(MODE_CYCLE, 1, OP_DIV, 9, 1, 4, 0, 0));
    instr_q.push_back(mk(MODE_CYCLE, 1, OP_LOAD, 10, 0, 1, 16'hFFFF, 0));
    instr_q.push_back(mk(MODE_CYCLE, 1, OP_STORE, 7, 0, 2, 0, 0));
    instr_q.push_back(mk(MODE_CYCLE, 1, 3'd6, 12, 1, 1, 0, 0));
    instr_q.push_back(mk(MODE_CYCLE, 1, 3'd7, 12, 1, 1, 0, 0));
    instr_q.push_back(mk(2'd3, 1, OP_ADD, 12, 1, 1, 0, 32'hFFFF_FFFF));
    instr_q.push_back(mk(MODE_CYCLE, 1, OP_ADD, 11, 5, 5, 0, 0));
    instr_q.push_back(mk(MODE_CYCLE, 1, OP_ADD, 12, 11, 31, 0, 0));
    instr_q.push_back(mk(MODE_CYCLE, 1, OP_ADD, 13, 12, 31, 0, 0));
    instr_q.push_back(mk(MODE_CYCLE, 1, OP_SUB, 14, 31, 31, 0, 0));
    instr_q.push_back(mk(MODE_READ, 0, OP_ADD, 7, 0, 0, 0, 0));
    for (int k = 0; k < 4; k++) instr_q.push_back(mk(MODE_CYCLE, 0, OP_ADD, 0, 0, 0, 0, 0));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      int n;
      for (int k = 0; k < NUM_OPS; k++) begin
        case (ph)
          0: write_latency(k, 6'd1);
          2: write_latency(k, 6'd63);
          default: write_latency(k, ($urandom_range(3) == 0) ? 6'd63
                                    : LAT_W'($urandom_range(1, 12)));
        endcase
      end
      n = (ph == 2) ? 60 : (ph == 3) ? 150 : 120;
      if (ph == 3) no_idle = 1;
      for (int k = 0; k < n; k++) instr_q.push_back(random_instr());
      drain();
    end

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

[files.f]
rtl/core/tiew_pkg.sv
rtl/core/tiew_if.sv
rtl/core/tiew_div.sv
rtl/core/tiew_dp.sv
rtl/core/tiew_ctrl.sv
rtl/core/tomasulo_issue_execute_writeback.sv
dv/tomasulo_issue_execute_writeback_tb.sv
